>>> rtl/psp_pkg.sv
// shared types and constants for the pcm sample packer
`timescale 1ns / 1ps

package psp_pkg;

  localparam int CHANNELS = 8;

  // saturation limits of the 24-bit word
  localparam logic signed [28:0] SAT_MAX = 29'sd8388607;
  localparam logic signed [28:0] SAT_MIN = -29'sd8388608;

  // truncation bias for narrow outputs
  localparam logic signed [28:0] BIAS_8 = 29'sd32768;
  localparam logic signed [28:0] BIAS_16 = 29'sd128;

  localparam logic [23:0] SIGN_FLIP = 24'h800000;

  typedef enum logic [2:0] {
    REG_SAMPLE_BYTES    = 3'd0,
    REG_BIG_ENDIAN      = 3'd1,
    REG_SIGNED_OUT      = 3'd2,
    REG_SOURCE_MASK     = 3'd3,
    REG_ACTIVE_CHANNELS = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [1:0] sample_bytes;
    logic       big_endian;
    logic       signed_out;
    logic [7:0] source_mask;
    logic [3:0] active_channels;
  } cfg_t;

  // rounded sample on its way to formatting
  typedef struct packed {
    logic signed [27:0] q;
    logic               live;
    logic               last;
  } rnd_t;

  // bytes in output order, ready to serialize
  typedef struct packed {
    logic [2:0][7:0] seq;
    logic [1:0]      nbytes;
    logic            last;
  } pack_t;

endpackage

>>> rtl/psp_round.sv
// input register, channel filter and round-half-even scaling to 24 bits
`timescale 1ns / 1ps

module psp_round (
  input  logic                 clk,
  input  logic                 rst,
  input  psp_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   sample_value,
  input  logic [2:0]           channel_index,
  input  logic                 channel_muted,
  input  logic                 block_last,
  output logic                 rnd_valid,
  input  logic                 rnd_ready,
  output psp_pkg::rnd_t        rnd
);
  import psp_pkg::*;

  logic               a_valid;
  logic signed [31:0] a_raw;
  logic               a_live;
  logic               a_last;
  logic               a_ready;
  logic               drop;
  logic               b_valid;
  logic               b_ready;
  rnd_t               b_data;
  logic signed [26:0] q_floor;
  logic [4:0]         rem;
  logic               round_up;

  assign b_ready  = !b_valid || rnd_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_stall = !a_ready;

  // channels past the active count or the channel limit produce nothing
  assign drop = ({1'b0, channel_index} >= cfg.active_channels) ||
                (32'(channel_index) >= CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_raw  <= sample_value;
      a_live <= !channel_muted && cfg.source_mask[channel_index];
      a_last <= block_last;
    end
  end

  // floor(x/32) then round half to even on the dropped five bits
  assign q_floor  = a_raw[31:5];
  assign rem      = a_raw[4:0];
  assign round_up = (rem > 5'd16) || ((rem == 5'd16) && q_floor[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_data.q    <= 28'(q_floor) + 28'(round_up);
      b_data.live <= a_live;
      b_data.last <= a_last;
    end
  end

  assign rnd_valid = b_valid;
  assign rnd       = b_data;

endmodule

>>> rtl/psp_format.sv
// bias, saturation, silence, offset flip and byte ordering
`timescale 1ns / 1ps

module psp_format (
  input  logic           clk,
  input  logic           rst,
  input  psp_pkg::cfg_t  cfg,
  input  logic           rnd_valid,
  output logic           rnd_ready,
  input  psp_pkg::rnd_t  rnd,
  output logic           pack_valid,
  input  logic           pack_ready,
  output psp_pkg::pack_t pack
);
  import psp_pkg::*;

  logic              c_valid;
  pack_t             c_data;
  logic [1:0]        nbytes;
  logic signed [28:0] bias;
  logic signed [28:0] v;
  logic [23:0]       sat;
  logic [23:0]       word;
  logic [2:0][7:0]   seq;

  assign rnd_ready = !c_valid || pack_ready;

  always_comb begin
    nbytes = (cfg.sample_bytes == 2'd0) ? 2'd1 : cfg.sample_bytes;
    case (nbytes)
      2'd1:    bias = BIAS_8;
      2'd2:    bias = BIAS_16;
      default: bias = '0;
    endcase
    v = 29'(rnd.q) + bias;
    if (v > SAT_MAX) begin
      sat = SAT_MAX[23:0];
    end else if (v < SAT_MIN) begin
      sat = SAT_MIN[23:0];
    end else begin
      sat = v[23:0];
    end
    word = (rnd.live ? sat : 24'd0) ^ (cfg.signed_out ? 24'd0 : SIGN_FLIP);
    // seq[0] goes out first
    seq = '0;
    if (cfg.big_endian) begin
      seq[0] = word[23:16];
      seq[1] = word[15:8];
      seq[2] = word[7:0];
    end else begin
      case (nbytes)
        2'd1: begin
          seq[0] = word[23:16];
        end
        2'd2: begin
          seq[0] = word[15:8];
          seq[1] = word[23:16];
        end
        default: begin
          seq[0] = word[7:0];
          seq[1] = word[15:8];
          seq[2] = word[23:16];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (rnd_ready) begin
      c_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rnd_ready && rnd_valid) begin
      c_data.seq    <= seq;
      c_data.nbytes <= nbytes;
      c_data.last   <= rnd.last;
    end
  end

  assign pack_valid = c_valid;
  assign pack       = c_data;

endmodule

>>> rtl/psp_serial.sv
// byte serializer with registered output
`timescale 1ns / 1ps

module psp_serial (
  input  logic           clk,
  input  logic           rst,
  input  logic           pack_valid,
  output logic           pack_ready,
  input  psp_pkg::pack_t pack,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           sample_done,
  output logic           block_done
);
  import psp_pkg::*;

  logic            busy;
  logic [2:0][7:0] seq;
  logic [1:0]      nbytes;
  logic            last;
  logic [1:0]      k;
  logic            fin;
  logic            out_load;
  logic            o_valid;

  assign out_load   = !o_valid || !out_stall;
  assign fin        = (2'(k + 2'd1) == nbytes);
  assign pack_ready = !busy || (fin && out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (out_load) begin
        o_valid <= busy;
      end
      if (pack_ready) begin
        busy <= pack_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && busy) begin
      out_byte    <= seq[k];
      sample_done <= fin;
      block_done  <= fin && last;
    end
    if (pack_ready) begin
      seq    <= pack.seq;
      nbytes <= pack.nbytes;
      last   <= pack.last;
      k      <= 2'd0;
    end else if (busy && out_load) begin
      k <= 2'(k + 2'd1);
    end
  end

  assign out_valid = o_valid;

endmodule

>>> rtl/pcm_sample_packer_core.sv
// top level of the pcm sample packer
`timescale 1ns / 1ps

// Takes one Q3.28 audio sample per transaction and emits 1, 2 or 3 PCM bytes,
// one per output transaction, rounded half to even to 24 bits, biased,
// saturated and ordered per the configuration registers. Samples on
// muted or masked channels pack silence; samples on channels at or past
// active_channels give no bytes. A new sample is accepted every cycle while
// the pipeline drains; the sustained rate is set by the one-byte output
// register, which sends the 1 to 3 bytes of each sample one at a time. A
// sample passes the input, round, format, serializer and output registers.
// Configuration writes are to be made while no sample is in flight.

module pcm_sample_packer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_value,
  input  logic [2:0]         channel_index,
  input  logic               channel_muted,
  input  logic               block_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               sample_done,
  output logic               block_done
);
  import psp_pkg::*;

  cfg_t  cfg;
  logic  rnd_valid;
  logic  rnd_ready;
  rnd_t  rnd;
  logic  pack_valid;
  logic  pack_ready;
  pack_t pack;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_bytes    <= 2'd2;
      cfg.big_endian      <= 1'b0;
      cfg.signed_out      <= 1'b1;
      cfg.source_mask     <= 8'hFF;
      cfg.active_channels <= 4'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_BYTES:    cfg.sample_bytes    <= cfg_data[1:0];
        REG_BIG_ENDIAN:      cfg.big_endian      <= cfg_data[0];
        REG_SIGNED_OUT:      cfg.signed_out      <= cfg_data[0];
        REG_SOURCE_MASK:     cfg.source_mask     <= cfg_data;
        REG_ACTIVE_CHANNELS: cfg.active_channels <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  psp_round u_round (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .channel_index (channel_index),
    .channel_muted (channel_muted),
    .block_last    (block_last),
    .rnd_valid     (rnd_valid),
    .rnd_ready     (rnd_ready),
    .rnd           (rnd)
  );

  psp_format u_format (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rnd_valid  (rnd_valid),
    .rnd_ready  (rnd_ready),
    .rnd        (rnd),
    .pack_valid (pack_valid),
    .pack_ready (pack_ready),
    .pack       (pack)
  );

  psp_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .pack_valid  (pack_valid),
    .pack_ready  (pack_ready),
    .pack        (pack),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .sample_done (sample_done),
    .block_done  (block_done)
  );

endmodule

>>> tb/sv/pcm_pack_checker.sv
// checker that predicts the packed pcm bytes of each sample and compares them with the output
`timescale 1ns / 1ps

module pcm_pack_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] sample_value,
  input  logic [2:0]         channel_index,
  input  logic               channel_muted,
  input  logic               block_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_byte,
  input  logic               sample_done,
  input  logic               block_done,
  output int                 fail_count,
  output int                 pending
);
  import psp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       sample_done;
    logic       block_done;
  } pcm_byte_t;

  localparam cfg_t FMT_RESET = '{sample_bytes: 2'd2, big_endian: 1'b0, signed_out: 1'b1,
                                 source_mask: 8'hFF, active_channels: 4'd2};

  cfg_t      fmt = FMT_RESET;
  pcm_byte_t expected_bytes[$];
  int        mismatches = 0;
  int        bytes_seen = 0;

  // 24-bit word for one sample, before byte ordering
  function automatic logic [23:0] pack_word(input logic signed [31:0] x, input logic live,
                                            input int nbytes);
    longint      v;
    logic [23:0] w;
    w = '0;
    if (live) begin
      v = longint'(x) >>> 5;
      // round half to even on the five dropped fraction bits
      if (x[4:0] > 5'd16 || (x[4:0] == 5'd16 && v[0])) v = v + 1;
      if (nbytes == 1) v = v + longint'(BIAS_8);
      else if (nbytes == 2) v = v + longint'(BIAS_16);
      if (v > longint'(SAT_MAX)) v = longint'(SAT_MAX);
      if (v < longint'(SAT_MIN)) v = longint'(SAT_MIN);
      w = v[23:0];
    end
    if (!fmt.signed_out) w = w ^ SIGN_FLIP;
    return w;
  endfunction

  function automatic void queue_sample_bytes(input logic signed [31:0] x, input logic [2:0] ch,
                                             input logic muted, input logic last);
    int          n;
    int          k;
    logic [23:0] w;
    logic [7:0]  msb_first [3];
    pcm_byte_t   item;
    n = (fmt.sample_bytes == 2'd0) ? 1 : int'(fmt.sample_bytes);
    if ({1'b0, ch} >= fmt.active_channels || int'(ch) >= CHANNELS) return;
    w = pack_word(x, !muted && fmt.source_mask[ch], n);
    msb_first[0] = w[23:16];
    msb_first[1] = w[15:8];
    msb_first[2] = w[7:0];
    for (k = 0; k < n; k++) begin
      item.data        = fmt.big_endian ? msb_first[k] : msb_first[n - 1 - k];
      item.sample_done = (k == n - 1);
      item.block_done  = (k == n - 1) && last;
      expected_bytes.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    pcm_byte_t want;
    if (rst) begin
      fmt = FMT_RESET;
      expected_bytes.delete();
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_SAMPLE_BYTES:    fmt.sample_bytes    = cfg_data[1:0];
          REG_BIG_ENDIAN:      fmt.big_endian      = cfg_data[0];
          REG_SIGNED_OUT:      fmt.signed_out      = cfg_data[0];
          REG_SOURCE_MASK:     fmt.source_mask     = cfg_data;
          REG_ACTIVE_CHANNELS: fmt.active_channels = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        queue_sample_bytes(sample_value, channel_index, channel_muted, block_last);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte %0d: unexpected transaction, data %h sample_done %b block_done %b",
                     bytes_seen, out_byte, sample_done, block_done);
        end else begin
          want = expected_bytes.pop_front();
          if ({out_byte, sample_done, block_done} !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("byte %0d: expected data %h sd %b bd %b, got data %h sd %b bd %b",
                       bytes_seen, want.data, want.sample_done, want.block_done,
                       out_byte, sample_done, block_done);
          end
        end
        bytes_seen++;
      end
    end
    fail_count <= mismatches;
    pending    <= expected_bytes.size();
  end

endmodule

>>> tb/sv/pcm_sample_packer_core_tb.sv
// testbench top for the pcm sample packer: stimulus, output stall pattern and verdict
`timescale 1ns / 1ps

module pcm_sample_packer_core_tb;
  import psp_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic signed [31:0] sample_value = '0;
  logic [2:0]         channel_index = '0;
  logic               channel_muted = 1'b0;
  logic               block_last = 1'b0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               sample_done;
  logic               block_done;
  int                 fail_count;
  int                 pending;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          chan_limit = 2;

  pcm_sample_packer_core DUT (.*);

  pcm_pack_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("pcm_sample_packer_core_tb NOT OK");
    $finish;
  end

  // receiver stalls in stretches, each with its own pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_left % 5 < 2);
    endcase
  end

  task automatic send_sample(input logic signed [31:0] value, input logic [2:0] ch,
                             input logic muted, input logic last);
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    sample_value  <= value;
    channel_index <= ch;
    channel_muted <= muted;
    block_last    <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every predicted byte is out, then let dropped samples clear
  task automatic wait_for_bytes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_format(input logic [1:0] nbytes, input logic big, input logic sgn,
                                input logic [7:0] mask, input logic [3:0] nch);
    reg_index_t regs [5];
    logic [7:0] vals [5];
    int         i;
    regs = '{REG_SAMPLE_BYTES, REG_BIG_ENDIAN, REG_SIGNED_OUT, REG_SOURCE_MASK,
             REG_ACTIVE_CHANNELS};
    // unused upper data bits carry noise
    vals = '{{6'($urandom), nbytes}, {7'($urandom), big}, {7'($urandom), sgn}, mask,
             {4'($urandom), nch}};
    for (i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    chan_limit = nch;
  endtask

  function automatic logic signed [31:0] random_q28();
    int                 pick;
    logic signed [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      v = $urandom;
    end else if (pick < 50) begin
      // small values, where the rounding ties show up
      v = $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
    end else if (pick < 75) begin
      // close to full scale, where saturation and the narrow-output bias meet
      v = 32'sd268435456 - $signed(32'($urandom_range(0, 2097152)));
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = $signed($urandom) >>> $urandom_range(1, 12);
    end
    return v;
  endfunction

  // interleaved blocks of whole frames, mixed with stray samples on any channel
  task automatic stream_random(input int live_target);
    int         live;
    int         frames;
    int         nch;
    int         f;
    int         c;
    logic [7:0] mute_bits;
    logic [2:0] ch;
    live = 0;
    nch = (chan_limit > CHANNELS) ? CHANNELS : chan_limit;
    while (live < live_target) begin
      if ($urandom_range(0, 5) == 0) begin
        ch = $urandom_range(0, 7);
        send_sample(random_q28(), ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (ch < chan_limit) live++;
      end else begin
        frames = $urandom_range(1, 3);
        mute_bits = $urandom & $urandom & $urandom;
        for (f = 0; f < frames; f++) begin
          for (c = 0; c < nch; c++) begin
            send_sample(random_q28(), c[2:0], mute_bits[c], f == frames - 1 && c == nch - 1);
            live++;
          end
        end
      end
    end
  endtask

  task automatic random_phase(input logic [1:0] nbytes, input logic big, input logic sgn,
                              input logic [7:0] mask, input logic [3:0] nch, input bit gaps);
    program_format(nbytes, big, sgn, mask, nch);
    gaps_on = gaps;
    stream_random(20);
    wait_for_bytes();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset format: 16-bit little endian two's complement on channels 0 and 1
    send_sample(32'sh0000_0000, 3'd0, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 3'd1, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 3'd0, 1'b0, 1'b0);
    send_sample(32'sh0000_0010, 3'd1, 1'b0, 1'b0);
    send_sample(32'sh0000_0030, 3'd0, 1'b0, 1'b0);
    send_sample(32'shFFFF_FFF0, 3'd1, 1'b0, 1'b0);
    send_sample(32'sh1000_0000, 3'd0, 1'b0, 1'b0);
    send_sample(32'sh1234_5678, 3'd1, 1'b1, 1'b0);
    // block end on a dropped channel is lost
    send_sample(32'sh0555_5555, 3'd2, 1'b0, 1'b1);
    send_sample(32'shF000_0020, 3'd0, 1'b0, 1'b0);
    send_sample(32'sh0FFF_FFE0, 3'd1, 1'b0, 1'b1);
    wait_for_bytes();

    // 24-bit big endian offset binary, odd channels masked to silence
    program_format(2'd3, 1'b1, 1'b0, 8'h55, 4'd8);
    send_sample(32'sh0ABC_DEF0, 3'd1, 1'b0, 1'b0);
    send_sample(32'sh7FFF_FFFF, 3'd0, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 3'd6, 1'b0, 1'b0);
    send_sample(32'sh0001_2345, 3'd4, 1'b1, 1'b0);
    send_sample(32'shFFFE_DCBA, 3'd7, 1'b0, 1'b1);
    wait_for_bytes();

    // no active channels: everything dropped
    program_format(2'd0, 1'b0, 1'b1, 8'hFF, 4'd0);
    send_sample(32'sh0123_4567, 3'd0, 1'b0, 1'b0);
    send_sample(32'sh8765_4321, 3'd0, 1'b0, 1'b1);
    wait_for_bytes();

    // sample width zero packs as 8-bit
    program_format(2'd0, 1'b1, 1'b1, 8'hFF, 4'd8);
    send_sample(32'sh7FFF_FFFF, 3'd3, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 3'd5, 1'b0, 1'b0);
    send_sample(32'sh0000_0010, 3'd7, 1'b0, 1'b1);
    wait_for_bytes();

    random_phase(2'd1, 1'b0, 1'b1, 8'hFF, 4'd8, 1'b1);
    random_phase(2'd3, 1'b1, 1'b0, 8'hA5, 4'd4, 1'b0);
    random_phase(2'd2, 1'b1, 1'b1, 8'h00, 4'd1, 1'b1);
    random_phase(2'd0, 1'b0, 1'b0, 8'hFF, 4'd15, 1'b1);
    random_phase(2'd3, 1'b0, 1'b1, 8'h0F, 4'd8, 1'b0);
    random_phase(2'd1, 1'b1, 1'b0, 8'hFF, 4'd3, 1'b1);
    random_phase(2'd2, 1'b0, 1'b1, 8'hFF, 4'd2, 1'b1);
    random_phase(2'd3, 1'b1, 1'b1, 8'hFE, 4'd7, 1'b1);

    if (fail_count == 0) begin
      $display("pcm_sample_packer_core_tb OK");
    end else begin
      $display("pcm_sample_packer_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/psp_pkg.sv
rtl/psp_round.sv
rtl/psp_format.sv
rtl/psp_serial.sv
rtl/pcm_sample_packer_core.sv
tb/sv/pcm_pack_checker.sv
tb/sv/pcm_sample_packer_core_tb.sv
